[hw/rtl/flhr_pkg.sv]
// Package for the five-level hysteresis regulator.
// Widths, threshold register indexes, level codes and shared types.
// No dependencies.
package flhr_pkg;

    // Sample width (signed, 4 fraction bits)
    localparam int VALUE_WIDTH = 16;
    // Error width: one extra bit so setpoint - measured never overflows
    localparam int ERR_W       = VALUE_WIDTH + 1;
    // Threshold register width (unsigned)
    localparam int THR_W       = 15;
    // Compare width: holds the error and a negated threshold with margin
    localparam int CMP_W       = ((ERR_W > THR_W + 1) ? ERR_W : THR_W + 1) + 1;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_HIGH = 2'd3;

    // Threshold reset values
    localparam logic [THR_W-1:0] INNER_LOW_RST  = 15'd0;
    localparam logic [THR_W-1:0] INNER_HIGH_RST = 15'd80;
    localparam logic [THR_W-1:0] OUTER_LOW_RST  = 15'd240;
    localparam logic [THR_W-1:0] OUTER_HIGH_RST = 15'd640;

    // Output level codes, two's complement
    localparam int LEVEL_W = 3;
    typedef logic signed [LEVEL_W-1:0] level_t;
    localparam level_t LEVEL_NEG2 = -3'sd2;
    localparam level_t LEVEL_NEG1 = -3'sd1;
    localparam level_t LEVEL_OFF  =  3'sd0;
    localparam level_t LEVEL_POS1 =  3'sd1;
    localparam level_t LEVEL_POS2 =  3'sd2;

    // Threshold set
    typedef struct packed {
        logic [THR_W-1:0] l1;
        logic [THR_W-1:0] h1;
        logic [THR_W-1:0] l2;
        logic [THR_W-1:0] h2;
    } thr_t;

    // Decision for one sample
    typedef struct packed {
        level_t level;
        logic   ok;
    } decision_t;

endpackage

[hw/rtl/flhr_sample_if.sv]
// Sample request channel: setpoint and measured value.
// Depends on flhr_pkg.
interface flhr_sample_if;
    import flhr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] setpoint;
    logic signed [VALUE_WIDTH-1:0] measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

[hw/rtl/flhr_result_if.sv]
// Result request channel: drive level and threshold status.
// Depends on flhr_pkg.
interface flhr_result_if;
    import flhr_pkg::*;

    logic   valid;
    logic   ready;
    level_t drive_level;
    logic   params_ok;

    modport source (output valid, output drive_level, output params_ok, input ready);
    modport sink   (input valid, input drive_level, input params_ok, output ready);
endinterface

[hw/rtl/flhr_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on flhr_pkg.
interface flhr_cfg_if;
    import flhr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/flhr_level_logic.sv]
// Next-level decision: error, threshold check and the five hysteresis rules.
// Purely combinational. Depends on flhr_pkg.
module flhr_level_logic (
    input  logic signed [flhr_pkg::VALUE_WIDTH-1:0] setpoint,
    input  logic signed [flhr_pkg::VALUE_WIDTH-1:0] measured,
    input  flhr_pkg::level_t                        prev_level,
    input  flhr_pkg::thr_t                          thr,
    output flhr_pkg::decision_t                     decision
);
    import flhr_pkg::*;

    logic signed [ERR_W-1:0] err;
    logic signed [CMP_W-1:0] e;
    logic signed [CMP_W-1:0] pl1, ph1, pl2, ph2;
    logic signed [CMP_W-1:0] nl1, nh1, nl2, nh2;
    logic                    ok;
    logic                    y_p2, y_p1, y_z, y_n1, y_n2;
    level_t                  rule_level;

    // Exact error, then widen for the compares
    assign err = ERR_W'(setpoint) - ERR_W'(measured);
    assign e   = CMP_W'(err);

    // Thresholds and their negations
    assign pl1 = signed'(CMP_W'(thr.l1));
    assign ph1 = signed'(CMP_W'(thr.h1));
    assign pl2 = signed'(CMP_W'(thr.l2));
    assign ph2 = signed'(CMP_W'(thr.h2));
    assign nl1 = -pl1;
    assign nh1 = -ph1;
    assign nl2 = -pl2;
    assign nh2 = -ph2;

    // Strict ordering; nonnegativity holds by construction
    assign ok = (thr.l1 < thr.h1) && (thr.h1 < thr.l2) && (thr.l2 < thr.h2);

    assign y_p2 = (prev_level == LEVEL_POS2);
    assign y_p1 = (prev_level == LEVEL_POS1);
    assign y_z  = (prev_level == LEVEL_OFF);
    assign y_n1 = (prev_level == LEVEL_NEG1);
    assign y_n2 = (prev_level == LEVEL_NEG2);

    // Rules in priority order; fall through to off
    always_comb
    begin
        if (e >= ph2 || (e >= pl2 && e < ph2 && (y_p2 || y_z)))
        begin
            rule_level = LEVEL_POS2;
        end
        else if ((e >= ph1 && e < pl2) || (e >= pl2 && e < ph2 && y_p1) ||
                 (e > pl1 && e <= ph1 && y_p1))
        begin
            rule_level = LEVEL_POS1;
        end
        else if ((e > nl1 && e < pl1) || (e > pl1 && e < ph1 && y_z) ||
                 (e < nl1 && e > nh1 && y_z))
        begin
            rule_level = LEVEL_OFF;
        end
        else if ((e <= nh1 && e > nl2) || (e <= nl2 && e > nh2 && y_n1) ||
                 (e < nl1 && e >= nh1 && y_n1))
        begin
            rule_level = LEVEL_NEG1;
        end
        else if (e <= nh2 || (e <= nl2 && e > nh2 && (y_n2 || y_z)))
        begin
            rule_level = LEVEL_NEG2;
        end
        else
        begin
            rule_level = LEVEL_OFF;
        end
    end

    // Bad thresholds hold the level
    assign decision.level = ok ? rule_level : prev_level;
    assign decision.ok    = ok;

endmodule

[hw/rtl/five_level_hysteresis_regulator_unit.sv]
// Five-level hysteresis regulator, top level.
// An accepted sample is registered in the input stage, and its decision in the result register.
// Throughput: one sample per cycle while the result sink does not stall; the level loop closes
// through the subtract-and-compare logic between the input register and the level register.
// Reset: thresholds 0/80/240/640, level off, both stages empty.
// Depends on flhr_pkg, the channel interfaces and flhr_level_logic.
module five_level_hysteresis_regulator_unit (
    input  logic         clk,
    input  logic         rst_n,
    flhr_cfg_if.sink     cfg,
    flhr_sample_if.sink  sample,
    flhr_result_if.source result
);
    import flhr_pkg::*;

    thr_t                          thr_reg;
    level_t                        level_reg;
    logic                          s1_valid_reg;
    logic signed [VALUE_WIDTH-1:0] s1_setpoint_reg;
    logic signed [VALUE_WIDTH-1:0] s1_measured_reg;
    logic                          out_valid_reg;
    level_t                        out_level_reg;
    logic                          out_ok_reg;

    decision_t decision;
    logic      out_free;
    logic      advance;
    logic      take_in;

    // Handshake: stage 1 moves when the result register is free
    assign out_free = !out_valid_reg || result.ready;
    assign advance  = s1_valid_reg && out_free;
    assign take_in  = sample.valid && sample.ready;

    assign sample.ready = !s1_valid_reg || out_free;
    assign cfg.ready    = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.drive_level = out_level_reg;
    assign result.params_ok   = out_ok_reg;

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.l1 <= INNER_LOW_RST;
            thr_reg.h1 <= INNER_HIGH_RST;
            thr_reg.l2 <= OUTER_LOW_RST;
            thr_reg.h2 <= OUTER_HIGH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_INNER_LOW:  thr_reg.l1 <= cfg.data;
                REG_INNER_HIGH: thr_reg.h1 <= cfg.data;
                REG_OUTER_LOW:  thr_reg.l2 <= cfg.data;
                REG_OUTER_HIGH: thr_reg.h2 <= cfg.data;
                default:        thr_reg    <= thr_reg;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_setpoint_reg <= sample.setpoint;
            s1_measured_reg <= sample.measured;
        end
    end

    // Decision logic
    flhr_level_logic u_level_logic (
        .setpoint   (s1_setpoint_reg),
        .measured   (s1_measured_reg),
        .prev_level (level_reg),
        .thr        (thr_reg),
        .decision   (decision)
    );

    // Level state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LEVEL_OFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                level_reg <= decision.level;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_level_reg <= decision.level;
            out_ok_reg    <= decision.ok;
        end
    end

endmodule

[test/testbench.sv]
// Testbench for five_level_hysteresis_regulator_unit: a directed table, then random samples
// over several threshold settings, each result checked against a level predictor.
// Depends on flhr_pkg, the channel interfaces and the regulator RTL.
`timescale 1ns / 1ps

module testbench;
    import flhr_pkg::*;

    localparam int PHASE_COUNT    = 13;
    localparam int PHASE_ITEMS    = 150;
    localparam int PRESSURE_PHASE = 6;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_NS     = 5_000_000;
    localparam int PROBE_COUNT    = 25;

    // One directed sample; level is only meaningful when typed is set
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] setpoint;
        logic signed [VALUE_WIDTH-1:0] measured;
        logic                          typed;
        level_t                        level;
    } probe_t;

    logic clk = 1'b0;
    logic rst_n;

    flhr_cfg_if    cfg_ch ();
    flhr_sample_if sample_ch ();
    flhr_result_if result_ch ();

    five_level_hysteresis_regulator_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (sample_ch),
        .result (result_ch)
    );

    // Predictor state
    thr_t      thr_model;
    level_t    level_model;
    decision_t pending_decisions [$];

    int error_count     = 0;
    int source_idle_pct = 0;
    int sink_stall_pct  = 0;
    bit hold_req        = 1'b0;
    bit hold_ack        = 1'b0;
    int hold_left       = 0;

    // Directed samples, run under the reset thresholds 0/80/240/640 from level off
    probe_t probe_table [PROBE_COUNT] = '{
        '{16'sd0,      16'sd0,      1'b1, LEVEL_OFF},   // zero error after reset
        '{16'sh7FFF,   16'sh8000,   1'b1, LEVEL_POS2},  // largest positive error
        '{16'sh8000,   16'sh7FFF,   1'b1, LEVEL_NEG2},  // largest negative error
        '{16'sh8000,   16'sh8000,   1'b0, LEVEL_OFF},
        '{16'sh7FFF,   16'sh7FFF,   1'b0, LEVEL_OFF},
        '{16'sd640,    16'sd0,      1'b1, LEVEL_POS2},  // exactly the outer high threshold
        '{16'sd639,    16'sd0,      1'b0, LEVEL_OFF},
        '{16'sd239,    16'sd0,      1'b0, LEVEL_OFF},
        '{16'sd0,     -16'sd240,    1'b0, LEVEL_OFF},
        '{16'sd80,     16'sd0,      1'b0, LEVEL_OFF},
        '{16'sd79,     16'sd0,      1'b0, LEVEL_OFF},
        '{16'sd1,      16'sd0,      1'b0, LEVEL_OFF},
        '{16'sd0,      16'sd0,      1'b0, LEVEL_OFF},
        '{16'sd79,     16'sd0,      1'b0, LEVEL_OFF},
        '{16'sd0,     -16'sd80,     1'b0, LEVEL_OFF},
        '{-16'sd1,     16'sd0,      1'b0, LEVEL_OFF},
        '{-16'sd79,    16'sd0,      1'b0, LEVEL_OFF},
        '{-16'sd80,    16'sd0,      1'b0, LEVEL_OFF},
        '{-16'sd240,   16'sd0,      1'b0, LEVEL_OFF},
        '{16'sd0,      16'sd639,    1'b0, LEVEL_OFF},
        '{-16'sd640,   16'sd0,      1'b1, LEVEL_NEG2},  // exactly minus the outer high threshold
        '{-16'sd300,   16'sd0,      1'b0, LEVEL_OFF},
        '{-16'sd100,   16'sd0,      1'b0, LEVEL_OFF},
        '{16'sd300,    16'sd0,      1'b0, LEVEL_OFF},   // outer band from level -1 falls to off
        '{16'sd300,    16'sd0,      1'b0, LEVEL_OFF}
    };

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit on run time
    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    function automatic logic thresholds_ordered();
        return thr_model.l1 < thr_model.h1 && thr_model.h1 < thr_model.l2 &&
               thr_model.l2 < thr_model.h2;
    endfunction

    // New level from the error and the previous level, first matching rule wins
    function automatic level_t next_drive_level(input int err, input level_t prev);
        int l1;
        int h1;
        int l2;
        int h2;
        l1 = int'(thr_model.l1);
        h1 = int'(thr_model.h1);
        l2 = int'(thr_model.l2);
        h2 = int'(thr_model.h2);
        if (err >= h2 || (err >= l2 && err < h2 && (prev == LEVEL_POS2 || prev == LEVEL_OFF)))
            return LEVEL_POS2;
        if ((err >= h1 && err < l2) || (err >= l2 && err < h2 && prev == LEVEL_POS1) ||
            (err > l1 && err <= h1 && prev == LEVEL_POS1))
            return LEVEL_POS1;
        if ((err > -l1 && err < l1) || (err > l1 && err < h1 && prev == LEVEL_OFF) ||
            (err < -l1 && err > -h1 && prev == LEVEL_OFF))
            return LEVEL_OFF;
        if ((err <= -h1 && err > -l2) || (err <= -l2 && err > -h2 && prev == LEVEL_NEG1) ||
            (err < -l1 && err >= -h1 && prev == LEVEL_NEG1))
            return LEVEL_NEG1;
        if (err <= -h2 || (err <= -l2 && err > -h2 && (prev == LEVEL_NEG2 || prev == LEVEL_OFF)))
            return LEVEL_NEG2;
        return LEVEL_OFF;
    endfunction

    // Offer one sample, wait for the request to be taken, then queue its decision
    task automatic offer_sample(input logic signed [VALUE_WIDTH-1:0] sp,
                                input logic signed [VALUE_WIDTH-1:0] ms);
        decision_t d;
        int        err;
        if (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < source_idle_pct)
                @(posedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.setpoint <= sp;
        sample_ch.measured <= ms;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        err  = int'(sp) - int'(ms);
        d.ok = thresholds_ordered();
        if (d.ok)
            level_model = next_drive_level(err, level_model);
        d.level = level_model;
        pending_decisions.push_back(d);
    endtask

    // Random sample: mostly errors close to one of the thresholds, some fully random
    task automatic offer_random_sample();
        logic [31:0] raw;
        int          pick;
        int          err;
        int          thr;
        int          lo;
        int          hi;
        int          sp;
        int          ms;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            raw = $urandom;
            offer_sample(raw[15:0], raw[31:16]);
        end
        else
        begin
            if (pick < 85)
            begin
                case ($urandom_range(3))
                    0:       thr = int'(thr_model.l1);
                    1:       thr = int'(thr_model.h1);
                    2:       thr = int'(thr_model.l2);
                    default: thr = int'(thr_model.h2);
                endcase
                err = thr + int'($urandom_range(6)) - 3;
                if ($urandom_range(1) == 1)
                    err = -err;
            end
            else
                err = int'($urandom_range(131070)) - 65535;
            // pick a setpoint so that both fields stay in range
            lo = (err - 32768 > -32768) ? err - 32768 : -32768;
            hi = (err + 32767 < 32767) ? err + 32767 : 32767;
            sp = lo + int'($urandom_range(hi - lo));
            ms = sp - err;
            offer_sample(sp[VALUE_WIDTH-1:0], ms[VALUE_WIDTH-1:0]);
        end
    endtask

    // One register write; valid stays high so writes can follow back to back
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [THR_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_INNER_LOW:  thr_model.l1 = value;
            REG_INNER_HIGH: thr_model.h1 = value;
            REG_OUTER_LOW:  thr_model.l2 = value;
            REG_OUTER_HIGH: thr_model.h2 = value;
            default: ;
        endcase
    endtask

    task automatic load_thresholds(input thr_t t);
        write_register(REG_INNER_LOW, t.l1);
        write_register(REG_INNER_HIGH, t.h1);
        write_register(REG_OUTER_LOW, t.l2);
        write_register(REG_OUTER_HIGH, t.h2);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [THR_W-1:0] threshold_gap();
        if ($urandom_range(3) == 0)
            return THR_W'(1 + $urandom_range(3));
        return THR_W'(1 + $urandom_range(8000));
    endfunction

    // Result sink: random stalls, plus one long hold when requested
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare each accepted result with the oldest expected decision
    always @(posedge clk)
    begin : check_results
        decision_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_decisions.size() == 0)
                report_mismatch("result with no decision pending");
            else
            begin
                want = pending_decisions.pop_front();
                if (result_ch.drive_level !== want.level)
                    report_mismatch($sformatf("drive_level got %0d want %0d",
                                              result_ch.drive_level, want.level));
                if (result_ch.params_ok !== want.ok)
                    report_mismatch($sformatf("params_ok got %0b want %0b",
                                              result_ch.params_ok, want.ok));
            end
        end
    end

    // Stimulus
    initial
    begin
        thr_t      t;
        decision_t typed_d;
        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_INNER_LOW;
        cfg_ch.data        = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.setpoint = '0;
        sample_ch.measured = '0;
        result_ch.ready    = 1'b0;
        thr_model          = '{INNER_LOW_RST, INNER_HIGH_RST, OUTER_LOW_RST, OUTER_HIGH_RST};
        level_model        = LEVEL_OFF;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            // new thresholds only once the block has gone quiet
            if (ph != 0)
            begin
                sample_ch.valid <= 1'b0;
                while (pending_decisions.size() != 0)
                    @(posedge clk);
                case (ph)
                    1:  t = '{15'd0, 15'd1, 15'd2, 15'd3};
                    2:  t = '{15'd32764, 15'd32765, 15'd32766, 15'd32767};
                    3:  t = '{15'd0, 15'd16, 15'd17, 15'd32767};
                    4:  t = '{15'd50, 15'd50, 15'd200, 15'd400};         // equal inner pair
                    5:  t = '{15'd400, 15'd300, 15'd200, 15'd100};       // reversed order
                    8:  t = '{15'd32767, 15'd32767, 15'd32767, 15'd32767};
                    10: t = '{15'd0, 15'd0, 15'd0, 15'd0};
                    12: t = '{INNER_LOW_RST, INNER_HIGH_RST, OUTER_LOW_RST, OUTER_HIGH_RST};
                    default:
                    begin
                        t.l1 = THR_W'($urandom_range(2000));
                        t.h1 = t.l1 + threshold_gap();
                        t.l2 = t.h1 + threshold_gap();
                        t.h2 = t.l2 + threshold_gap();
                    end
                endcase
                load_thresholds(t);
            end

            // idle pattern of this phase
            case (ph % 4)
                0:       begin source_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin source_idle_pct = 61; sink_stall_pct = 0;  end
                2:       begin source_idle_pct = 0;  sink_stall_pct = 61; end
                default: begin source_idle_pct = 38; sink_stall_pct = 38; end
            endcase
            // long sink hold while samples keep coming, so the block backs up
            if (ph == PRESSURE_PHASE)
            begin
                source_idle_pct = 0;
                hold_req        = !hold_req;
            end

            if (ph == 0)
            begin
                for (int i = 0; i < PROBE_COUNT; i++)
                begin
                    offer_sample(probe_table[i].setpoint, probe_table[i].measured);
                    if (probe_table[i].typed)
                    begin
                        typed_d.level          = probe_table[i].level;
                        typed_d.ok             = 1'b1;
                        pending_decisions[$]   = typed_d;
                    end
                end
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                offer_random_sample();
        end

        // drain and finish
        sample_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
